### design/sdp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, register indexes and control types for the
// starfield depth step and projection block. No dependencies.
package sdp_pkg;

  // Field widths.
  localparam int IDX_W      = 10;
  localparam int POS_W      = 32;
  localparam int DEPTH_W    = 31;
  localparam int HALF_W     = 15;
  localparam int SCALE_W    = 32;
  localparam int SCREEN_W   = 16;
  localparam int BRIGHT_W   = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd4;

  localparam logic [DEPTH_W-1:0] DEPTH_STEP_RST  = 31'd65536;
  localparam logic [DEPTH_W-1:0] NEAR_DEPTH_RST  = 31'd65536;
  localparam logic [DEPTH_W-1:0] FAR_DEPTH_RST   = 31'd655360;
  localparam logic [HALF_W-1:0]  HALF_WIDTH_RST  = 15'd960;
  localparam logic [HALF_W-1:0]  HALF_HEIGHT_RST = 15'd540;

  // Datapath widths for the divisions.
  localparam int NUM_W      = 48;             // projection numerator, signed
  localparam int BPROD_W    = DEPTH_W + 8;    // brightness numerator times 255
  localparam int SCALE_NW   = 33;             // numerator 2^32
  localparam int SCALE_QW   = 32;
  localparam int SCREEN_QW  = 15;
  localparam int BRIGHT_QW  = 8;

  localparam logic [SCALE_NW-1:0] SCALE_NUM = 33'h1_0000_0000;
  localparam logic [SCALE_W-1:0]  SCALE_SAT = 32'hFFFF_FFFF;
  localparam logic [SCREEN_W-1:0] SCREEN_MAX = 16'h7FFF;
  localparam logic [SCREEN_W-1:0] SCREEN_MIN = 16'h8000;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'd255;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MIN = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WRAP,
    ST_MUL,
    ST_SUM,
    ST_ABS,
    ST_START,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    BR_ZERO,
    BR_FULL,
    BR_DIV
  } bright_mode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic wrap;
    logic mul;
    logic sum;
    logic abs_en;
    logic start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

### design/sdp_star_if.sv
`timescale 1ns / 1ps
// Request channel carrying one star into the block.
// Depends on sdp_pkg for the field widths.
interface sdp_star_if import sdp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          star_index;
  logic signed [POS_W-1:0]   star_x;
  logic signed [POS_W-1:0]   star_y;
  logic [DEPTH_W-1:0]        star_depth;

  modport source (output valid, star_index, star_x, star_y, star_depth, input ready);
  modport sink   (input valid, star_index, star_x, star_y, star_depth, output ready);
endinterface

### design/sdp_proj_if.sv
`timescale 1ns / 1ps
// Request channel carrying one projected star out of the block.
// Depends on sdp_pkg for the field widths.
interface sdp_proj_if import sdp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [DEPTH_W-1:0]         new_depth;
  logic                       wrapped;
  logic [SCALE_W-1:0]         proj_scale;
  logic signed [SCREEN_W-1:0] screen_x;
  logic signed [SCREEN_W-1:0] screen_y;
  logic [BRIGHT_W-1:0]        brightness;
  logic [IDX_W-1:0]           draw_start;

  modport source (output valid, new_depth, wrapped, proj_scale, screen_x, screen_y,
                  brightness, draw_start, input ready);
  modport sink   (input valid, new_depth, wrapped, proj_scale, screen_x, screen_y,
                  brightness, draw_start, output ready);
endinterface

### design/sdp_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// The caller guarantees num < den * 2^QUO_W. Depends on nothing.
module sdp_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 31,
  parameter int QUO_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quot
);
  localparam int CntW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] work;
  logic [CntW-1:0]  cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // The low numerator bits shift out of the top of work while the quotient
  // bits shift in at the bottom.
  assign trial = {rem, work[QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DEN_W'(num >> QUO_W);
      work <= num[QUO_W-1:0];
    end else if (busy) begin
      rem  <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      work <= {work[QUO_W-2:0], ~diff[DEN_W]};
    end
  end
endmodule

### design/sdp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for one star at a time and the output valid flag.
// Depends on sdp_pkg for the state, command and status types.
module sdp_ctrl import sdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);
  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.abs_en = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // The result register may be refilled in the cycle it is taken.
        if (status.div_done && (!out_valid || out_ready)) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end
endmodule

### design/sdp_datapath.sv
`timescale 1ns / 1ps
// Configuration registers, depth step and wrap, products, four division lanes
// and the result register. Depends on sdp_pkg and sdp_div.
module sdp_datapath import sdp_pkg::*; #(
  parameter int STAR_COUNT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  input  logic [IDX_W-1:0]           star_index,
  input  logic signed [POS_W-1:0]    star_x,
  input  logic signed [POS_W-1:0]    star_y,
  input  logic [DEPTH_W-1:0]         star_depth,
  output logic [DEPTH_W-1:0]         new_depth,
  output logic                       wrapped,
  output logic [SCALE_W-1:0]         proj_scale,
  output logic signed [SCREEN_W-1:0] screen_x,
  output logic signed [SCREEN_W-1:0] screen_y,
  output logic [BRIGHT_W-1:0]        brightness,
  output logic [IDX_W-1:0]           draw_start
);
  // Index modulo the table size by a reciprocal multiply and one correction.
  localparam int ModShift = 20;
  localparam int ModMul   = (1 << ModShift) / STAR_COUNT;
  localparam int ModW     = $clog2(STAR_COUNT + 1);
  localparam int ModPW    = IDX_W + ModShift;
  localparam int ModQW    = IDX_W + ModW;
  localparam int ProdW    = HALF_W + DEPTH_W;
  localparam int ZsW      = DEPTH_W + 2;

  // Configuration.
  logic [DEPTH_W-1:0] depth_step;
  logic [DEPTH_W-1:0] near_depth;
  logic [DEPTH_W-1:0] far_depth;
  logic [HALF_W-1:0]  half_width;
  logic [HALF_W-1:0]  half_height;
  logic [IDX_W-1:0]   first_to_draw;

  // Working registers.
  logic [IDX_W-1:0]        idx_r;
  logic signed [POS_W-1:0] x_r;
  logic signed [POS_W-1:0] y_r;
  logic [DEPTH_W-1:0]      z_in;
  logic signed [ZsW-1:0]   z_step;
  logic                    wrap;
  logic [DEPTH_W-1:0]      z_depth;
  logic                    z_one;
  logic [IDX_W-1:0]        mod_q;
  logic [IDX_W-1:0]        mod_p;
  logic [ProdW-1:0]        prod_x;
  logic [ProdW-1:0]        prod_y;
  logic signed [DEPTH_W:0] bnum;
  logic [BPROD_W-1:0]      bprod;
  bright_mode_t            bmode;
  logic [NUM_W-1:0]        num_x;
  logic [NUM_W-1:0]        num_y;
  logic [NUM_W-1:0]        mag_x;
  logic [NUM_W-1:0]        mag_y;
  logic                    neg_x;
  logic                    neg_y;
  logic                    sat_x;
  logic                    sat_y;

  // Combinational terms.
  logic signed [ZsW-1:0]   span;
  logic signed [ZsW-1:0]   z_diff;
  logic signed [ZsW-1:0]   z_wrapped;
  logic [ModPW-1:0]        mod_full;
  logic [ModQW-1:0]        mod_prod;
  logic [IDX_W-1:0]        mod_rem;
  logic [IDX_W-1:0]        idx_mod;
  logic [NUM_W-1:0]        guard;

  // Divider lanes.
  logic                    busy_s;
  logic                    busy_x;
  logic                    busy_y;
  logic                    busy_b;
  logic [SCALE_QW-1:0]     quot_s;
  logic [SCREEN_QW-1:0]    quot_x;
  logic [SCREEN_QW-1:0]    quot_y;
  logic [BRIGHT_QW-1:0]    quot_b;

  function automatic logic [SCREEN_W-1:0] screen_value(
    input logic                 neg,
    input logic                 sat,
    input logic [SCREEN_QW-1:0] q
  );
    logic [SCREEN_W-1:0] pos;
    pos = {1'b0, q};
    if (sat) begin
      return neg ? SCREEN_MIN : SCREEN_MAX;
    end
    return neg ? (SCREEN_W'(0) - pos) : pos;
  endfunction

  assign span      = $signed({2'b00, far_depth}) - $signed({2'b00, near_depth});
  assign z_diff    = $signed({2'b00, z_in}) - $signed({2'b00, depth_step});
  assign z_wrapped = wrap ? (z_step + span) : z_step;
  assign mod_full  = ModPW'(idx_r) * ModPW'(ModMul);
  assign mod_prod  = ModQW'(mod_q) * ModQW'(STAR_COUNT);
  assign mod_rem   = idx_r - mod_p;
  assign idx_mod   = (ModQW'(mod_rem) >= ModQW'(STAR_COUNT))
                     ? IDX_W'(ModQW'(mod_rem) - ModQW'(STAR_COUNT)) : mod_rem;
  assign guard     = NUM_W'({z_depth, {SCREEN_QW{1'b0}}});

  assign status.div_done = !(busy_s || busy_x || busy_y || busy_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_step    <= DEPTH_STEP_RST;
      near_depth    <= NEAR_DEPTH_RST;
      far_depth     <= FAR_DEPTH_RST;
      half_width    <= HALF_WIDTH_RST;
      half_height   <= HALF_HEIGHT_RST;
      first_to_draw <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH_STEP:  depth_step  <= cfg_data;
          CFG_NEAR_DEPTH:  near_depth  <= cfg_data;
          CFG_FAR_DEPTH:   far_depth   <= cfg_data;
          CFG_HALF_WIDTH:  half_width  <= cfg_data[HALF_W-1:0];
          CFG_HALF_HEIGHT: half_height <= cfg_data[HALF_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.mul && wrap) begin
        first_to_draw <= idx_mod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= star_index;
      x_r   <= star_x;
      y_r   <= star_y;
      z_in  <= star_depth;
    end
    if (cmd.step) begin
      z_step <= z_diff;
      wrap   <= z_diff < $signed({2'b00, near_depth});
      mod_q  <= mod_full[ModPW-1:ModShift];
    end
    if (cmd.wrap) begin
      // A depth, wrapped or not, that falls below one clamps to one.
      z_depth <= (z_wrapped < 1) ? DEPTH_W'(1) : z_wrapped[DEPTH_W-1:0];
      mod_p   <= mod_prod[IDX_W-1:0];
    end
    if (cmd.mul) begin
      prod_x <= ProdW'(half_width) * ProdW'(z_depth);
      prod_y <= ProdW'(half_height) * ProdW'(z_depth);
      bnum   <= $signed({1'b0, far_depth}) - $signed({1'b0, z_depth});
      z_one  <= z_depth == DEPTH_W'(1);
    end
    if (cmd.sum) begin
      num_x <= {{(NUM_W-POS_W){x_r[POS_W-1]}}, x_r} + NUM_W'(prod_x);
      num_y <= {{(NUM_W-POS_W){y_r[POS_W-1]}}, y_r} + NUM_W'(prod_y);
      bprod <= BPROD_W'(bnum[DEPTH_W-1:0]) * BPROD_W'(BRIGHT_MAX);
      if (span <= 0) begin
        bmode <= (z_depth <= near_depth) ? BR_FULL : BR_ZERO;
      end else if (bnum <= 0) begin
        bmode <= BR_ZERO;
      end else if (bnum >= span) begin
        bmode <= BR_FULL;
      end else begin
        bmode <= BR_DIV;
      end
    end
    if (cmd.abs_en) begin
      neg_x <= num_x[NUM_W-1];
      neg_y <= num_y[NUM_W-1];
      mag_x <= num_x[NUM_W-1] ? (NUM_W'(0) - num_x) : num_x;
      mag_y <= num_y[NUM_W-1] ? (NUM_W'(0) - num_y) : num_y;
    end
    if (cmd.start) begin
      // Quotient magnitude of 32768 or more saturates in either direction.
      sat_x <= mag_x >= guard;
      sat_y <= mag_y >= guard;
    end
    if (cmd.commit) begin
      new_depth  <= z_depth;
      wrapped    <= wrap;
      proj_scale <= z_one ? SCALE_SAT : quot_s;
      screen_x   <= screen_value(neg_x, sat_x, quot_x);
      screen_y   <= screen_value(neg_y, sat_y, quot_y);
      draw_start <= first_to_draw;
      case (bmode)
        BR_ZERO: brightness <= BRIGHT_MIN;
        BR_FULL: brightness <= BRIGHT_MAX;
        BR_DIV:  brightness <= quot_b;
        default: brightness <= BRIGHT_MIN;
      endcase
    end
  end

  sdp_div #(
    .NUM_W(SCALE_NW),
    .DEN_W(DEPTH_W),
    .QUO_W(SCALE_QW)
  ) u_div_scale (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start),
    .num  (SCALE_NUM),
    .den  (z_depth),
    .busy (busy_s),
    .quot (quot_s)
  );

  sdp_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEPTH_W),
    .QUO_W(SCREEN_QW)
  ) u_div_x (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start),
    .num  (mag_x),
    .den  (z_depth),
    .busy (busy_x),
    .quot (quot_x)
  );

  sdp_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEPTH_W),
    .QUO_W(SCREEN_QW)
  ) u_div_y (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start),
    .num  (mag_y),
    .den  (z_depth),
    .busy (busy_y),
    .quot (quot_y)
  );

  sdp_div #(
    .NUM_W(BPROD_W),
    .DEN_W(DEPTH_W),
    .QUO_W(BRIGHT_QW)
  ) u_div_bright (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start),
    .num  (bprod),
    .den  (span[DEPTH_W-1:0]),
    .busy (busy_b),
    .quot (quot_b)
  );
endmodule

### design/starfield_depth_step_and_project.sv
`timescale 1ns / 1ps
// Starfield depth step and perspective projection, top level.
// Star requests arrive on the star channel (valid/ready) and each one
// produces exactly one request on the proj channel: new depth, wrap flag,
// 1/z scale, screen x and y, brightness and the current draw start index.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block is idle; the block does not enforce it.
// Index 0 is the depth step, 1 the near plane, 2 the far plane, 3 the half
// width and 4 the half height. Other indexes are ignored. One star is
// processed at a time, and a new star is taken only once the last one's
// result is committed: step, wrap, products, sums, magnitudes and divider
// start, followed by the 32 quotient bits of the bit-serial 1/z divider,
// which the screen and brightness dividers run beside.
// The result sits in an output register; while the receiver stalls, the
// next star is still accepted and worked on, and it waits for the register
// to be taken before it is written.
// Synchronous reset restores the register defaults, clears the draw start
// index and empties the output register. Depends on sdp_pkg, the two
// channel interfaces, sdp_ctrl and sdp_datapath.
module starfield_depth_step_and_project import sdp_pkg::*; #(
  parameter int STAR_COUNT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  sdp_star_if.sink              star,
  sdp_proj_if.source            proj,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  dp_cmd_t    cmd;
  dp_status_t status;

  sdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (star.valid),
    .in_ready (star.ready),
    .out_valid(proj.valid),
    .out_ready(proj.ready),
    .cmd      (cmd),
    .status   (status)
  );

  sdp_datapath #(
    .STAR_COUNT(STAR_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .star_index (star.star_index),
    .star_x     (star.star_x),
    .star_y     (star.star_y),
    .star_depth (star.star_depth),
    .new_depth  (proj.new_depth),
    .wrapped    (proj.wrapped),
    .proj_scale (proj.proj_scale),
    .screen_x   (proj.screen_x),
    .screen_y   (proj.screen_y),
    .brightness (proj.brightness),
    .draw_start (proj.draw_start)
  );
endmodule

### tb/tb_starfield_depth_step_and_project.sv
`timescale 1ns / 1ps
// Self-checking testbench for starfield_depth_step_and_project: directed star table, then
// random stars over many plane settings, checked against given values or a fixed-point projection model.
// Depends on sdp_pkg, sdp_star_if, sdp_proj_if and the block itself.
module tb_starfield_depth_step_and_project;
  import sdp_pkg::*;

  localparam int     STAR_COUNT = 1024;
  localparam longint MAX_DEPTH  = 64'h7FFF_FFFF;
  localparam longint MAX_HALF   = 32767;
  localparam int     SETTLE     = 45;    // a margin past the block's latency
  localparam int     PHASES     = 10;
  localparam int     PHASE_LEN  = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DEPTH_W-1:0]         depth;
    logic                       wrapped;
    logic [SCALE_W-1:0]         scale;
    logic signed [SCREEN_W-1:0] sx;
    logic signed [SCREEN_W-1:0] sy;
    logic [BRIGHT_W-1:0]        bright;
    logic [IDX_W-1:0]           start;
  } proj_t;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [DEPTH_W-1:0]      z;
    bit                      typed;
    proj_t                   want;
  } star_req_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    star_req_t             req;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sdp_star_if star_ch ();
  sdp_proj_if proj_ch ();

  starfield_depth_step_and_project #(.STAR_COUNT(STAR_COUNT)) u_top (
    .clk       (clk),
    .rst       (rst),
    .star      (star_ch),
    .proj      (proj_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and the draw start index.
  longint           cur_step, cur_near, cur_far, cur_half_w, cur_half_h;
  logic [IDX_W-1:0] last_wrap_idx;

  star_req_t sent_stars[$];
  proj_t     expected_proj[$];
  plan_row_t plan[$];

  bit steady;
  int fault_count   = 0;
  int checked_count = 0;
  int wrap_seen     = 0;
  int setting_count = 0;

  function automatic logic signed [SCREEN_W-1:0] screen_coord(longint pos, longint half,
                                                              longint z);
    longint q;
    q = (pos + half * z) / z;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SCREEN_W-1:0];
  endfunction

  // Steps one star and projects it; updates the draw start index on a wrap.
  function automatic proj_t project_star(logic [IDX_W-1:0] idx, logic signed [POS_W-1:0] x,
                                         logic signed [POS_W-1:0] y, logic [DEPTH_W-1:0] zin);
    proj_t  r;
    longint z, span, num, s, b;
    z    = longint'(zin) - cur_step;
    span = cur_far - cur_near;
    r.wrapped = (z < cur_near);
    if (r.wrapped) begin
      z = cur_far - (cur_near - z);
      last_wrap_idx = IDX_W'(int'(idx) % STAR_COUNT);
    end
    if (z < 1) z = 1;
    s = (longint'(1) << 32) / z;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    if (span <= 0) begin
      b = (z <= cur_near) ? 255 : 0;
    end else begin
      num = cur_far - z;
      if (num <= 0) b = 0;
      else if (num >= span) b = 255;
      else b = (num * 255) / span;
    end
    r.depth  = z[DEPTH_W-1:0];
    r.scale  = s[SCALE_W-1:0];
    r.sx     = screen_coord(longint'(x), cur_half_w, z);
    r.sy     = screen_coord(longint'(y), cur_half_h, z);
    r.bright = b[BRIGHT_W-1:0];
    r.start  = last_wrap_idx;
    return r;
  endfunction

  function automatic string show(proj_t p);
    return $sformatf("depth=%0d wrap=%0b scale=%0h sx=%0d sy=%0d bright=%0d start=%0d",
                     p.depth, p.wrapped, p.scale, p.sx, p.sy, p.bright, p.start);
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  function automatic plan_row_t star_row(int idx, logic signed [POS_W-1:0] x,
                                         logic signed [POS_W-1:0] y, longint z);
    plan_row_t row;
    row.is_cfg     = 1'b0;
    row.reg_idx    = CFG_DEPTH_STEP;
    row.reg_val    = '0;
    row.req.idx    = IDX_W'(idx);
    row.req.x      = x;
    row.req.y      = y;
    row.req.z      = DEPTH_W'(z);
    row.req.typed  = 1'b0;
    row.req.want   = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(int idx, logic signed [POS_W-1:0] x,
                                            logic signed [POS_W-1:0] y,
                                            longint z, proj_t want);
    plan_row_t row;
    row = star_row(idx, x, y, z);
    row.req.typed = 1'b1;
    row.req.want  = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] v);
    plan_row_t row;
    row = star_row(0, 0, 0, 1);
    row.is_cfg  = 1'b1;
    row.reg_idx = ri;
    row.reg_val = v;
    return row;
  endfunction

  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // Waits until every expected result has come out, then lets the pipeline settle.
  task automatic wait_idle();
    star_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_proj.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= v;
    case (ri)
      CFG_DEPTH_STEP:  cur_step   = v;
      CFG_NEAR_DEPTH:  cur_near   = v;
      CFG_FAR_DEPTH:   cur_far    = v;
      CFG_HALF_WIDTH:  cur_half_w = v[HALF_W-1:0];
      CFG_HALF_HEIGHT: cur_half_h = v[HALF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_star(star_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    sent_stars.insert(sent_stars.size(), r);
    if (gap > 0) begin
      star_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    star_ch.valid      <= 1'b1;
    star_ch.star_index <= r.idx;
    star_ch.star_x     <= r.x;
    star_ch.star_y     <= r.y;
    star_ch.star_depth <= r.z;
    @(posedge clk);
    while (!star_ch.ready) @(posedge clk);
  endtask

  // The model runs on the bus values at the accepting edge; typed rows keep their given result.
  always @(posedge clk) begin : star_watch
    star_req_t r;
    proj_t     p;
    if (!rst && star_ch.valid && star_ch.ready) begin
      r = sent_stars.pop_front();
      p = project_star(star_ch.star_index, star_ch.star_x, star_ch.star_y,
                       star_ch.star_depth);
      expected_proj.insert(expected_proj.size(), r.typed ? r.want : p);
    end
  end

  always @(posedge clk) begin : proj_check
    proj_t got;
    proj_t want;
    if (!rst && proj_ch.valid && proj_ch.ready) begin
      got = proj_t'{proj_ch.new_depth, proj_ch.wrapped, proj_ch.proj_scale, proj_ch.screen_x,
                    proj_ch.screen_y, proj_ch.brightness, proj_ch.draw_start};
      if (expected_proj.size() == 0) begin
        note_fault($sformatf("Unexpected result: %s", show(got)));
      end else begin
        want = expected_proj.pop_front();
        checked_count++;
        if (want.wrapped) wrap_seen++;
        if (got !== want)
          note_fault($sformatf("Result %0d mismatch:\n  got      %s\n  expected %s",
                               checked_count, show(got), show(want)));
      end
    end
  end

  // The receiver stalls a random number of cycles after each taken request.
  always @(posedge clk) begin : sink_side
    int n;
    int stall_left;
    if (rst) begin
      proj_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (proj_ch.valid && proj_ch.ready) begin
      n = steady ? 0 : $urandom_range(0, 5);
      stall_left = n;
      proj_ch.ready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      proj_ch.ready <= (stall_left == 0);
    end else begin
      proj_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout: results stopped arriving");
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    longint    st, nr, fr, hw, hh, lo, hi, d;
    int        pick;
    star_req_t r;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DEPTH_STEP;
    cfg_data           <= '0;
    star_ch.valid      <= 1'b0;
    star_ch.star_index <= '0;
    star_ch.star_x     <= '0;
    star_ch.star_y     <= '0;
    star_ch.star_depth <= '0;
    steady             = 1'b0;
    cur_step           = DEPTH_STEP_RST;
    cur_near           = NEAR_DEPTH_RST;
    cur_far            = FAR_DEPTH_RST;
    cur_half_w         = HALF_WIDTH_RST;
    cur_half_h         = HALF_HEIGHT_RST;
    last_wrap_idx      = '0;

    // Reset settings: plain step, a wrap with overshoot, a saturated screen x.
    add_row(checked_row(5, 0, 0, 327680,
                   proj_t'{31'd262144, 1'b0, 32'd16384, 16'sd960, 16'sd540, 8'd170, 10'd0}));
    add_row(checked_row(1023, 0, 0, 98304,
                   proj_t'{31'd622592, 1'b1, 32'd6898, 16'sd960, 16'sd540, 8'd14, 10'd1023}));
    add_row(checked_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 131072,
                   proj_t'{31'd65536, 1'b0, 32'd65536, 16'sd32767, -16'sd32228, 8'd255,
                           10'd1023}));
    add_row(star_row(512, -1, 1, 65536));
    add_row(star_row(1, 32'h4000_0000, 32'hC000_0000, 31'h7FFF_FFFF));
    add_row(star_row(2, 32'h0001_0000, -32'sh0001_0000, 1));
    add_row(star_row(3, 32'h1234_5678, -32'sh1234_5678, 720896));
    // A step wider than the whole span: the wrapped depth pins at one.
    add_row(reg_row(CFG_DEPTH_STEP, 31'd1310720));
    add_row(checked_row(100, 32'h7FFF_FFFF, 32'h8000_0000, 327680,
                   proj_t'{31'd1, 1'b1, 32'hFFFF_FFFF, 16'sd32767, -16'sd32768, 8'd255,
                           10'd100}));
    add_row(star_row(101, 0, 0, 31'h7FFF_FFFF));
    // Zero near plane: a depth stepped exactly to zero saturates without a wrap.
    add_row(reg_row(CFG_DEPTH_STEP, 31'd131072));
    add_row(reg_row(CFG_NEAR_DEPTH, 31'd0));
    add_row(star_row(200, 32'h0003_0000, -32'sh0003_0000, 131072));
    add_row(star_row(201, 32'h0000_8000, 32'h7FFF_0000, 65536));
    // Far plane below the near plane, then equal to it.
    add_row(reg_row(CFG_DEPTH_STEP, 31'd65536));
    add_row(reg_row(CFG_NEAR_DEPTH, 31'd655360));
    add_row(reg_row(CFG_FAR_DEPTH, 31'd131072));
    add_row(star_row(300, 32'h0010_0000, 32'hFFF0_0000, 327680));
    add_row(star_row(301, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    add_row(reg_row(CFG_NEAR_DEPTH, 31'd327680));
    add_row(reg_row(CFG_FAR_DEPTH, 31'd327680));
    add_row(star_row(302, 32'h0100_0000, -32'sh0100_0000, 31'h0010_0000));
    // Low extremes; the half registers keep only their low bits, spare indexes do nothing.
    add_row(reg_row(CFG_DEPTH_STEP, 31'd0));
    add_row(reg_row(CFG_NEAR_DEPTH, 31'd1));
    add_row(reg_row(CFG_FAR_DEPTH, 31'h7FFF_FFFF));
    add_row(reg_row(CFG_HALF_WIDTH, 31'h7FFF_FFFF));
    add_row(reg_row(CFG_HALF_HEIGHT, 31'h7FFF_8000));
    add_row(reg_row(CFG_SPARE_LO, 31'h0000_1234));
    add_row(reg_row(CFG_SPARE_HI, 31'h7FFF_FFFF));
    add_row(star_row(400, 0, 0, 1));
    add_row(star_row(401, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    // High extremes.
    add_row(reg_row(CFG_DEPTH_STEP, 31'h7FFF_FFFF));
    add_row(reg_row(CFG_NEAR_DEPTH, 31'h7FFF_FFFF));
    add_row(reg_row(CFG_HALF_WIDTH, 31'd0));
    add_row(reg_row(CFG_HALF_HEIGHT, 31'd32767));
    add_row(star_row(1023, 32'h5555_5555, 32'hAAAA_AAAA, 31'h7FFF_FFFF));
    add_row(star_row(0, 32'hAAAA_AAAA, 32'h5555_5555, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_star(plan[i].req);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin st = 65536; nr = 65536; fr = 655360; hw = 960; hh = 540; end
        1: begin st = 0; nr = 1; fr = MAX_DEPTH; hw = 0; hh = 0; end
        2: begin st = MAX_DEPTH; nr = MAX_DEPTH; fr = MAX_DEPTH; hw = MAX_HALF; hh = MAX_HALF; end
        3: begin
          nr = $urandom_range(65536, 1 << 24);
          fr = $urandom_range(1, nr);
          st = $urandom_range(0, nr);
          hw = $urandom_range(0, MAX_HALF);
          hh = $urandom_range(0, MAX_HALF);
        end
        4: begin
          nr = 0;
          fr = $urandom_range(65536, 1 << 22);
          st = $urandom_range(0, fr / 8);
          hw = $urandom_range(0, MAX_HALF);
          hh = $urandom_range(0, MAX_HALF);
        end
        default: begin
          nr = $urandom_range(1, 1 << 22);
          fr = nr + $urandom_range(1, 1 << 26);
          st = $urandom_range(0, (fr - nr) / 8 + 1);
          hw = $urandom_range(0, MAX_HALF);
          hh = $urandom_range(0, MAX_HALF);
        end
      endcase
      wait_idle();
      write_reg(CFG_DEPTH_STEP, CFG_DATA_W'(st));
      write_reg(CFG_NEAR_DEPTH, CFG_DATA_W'(nr));
      write_reg(CFG_FAR_DEPTH, CFG_DATA_W'(fr));
      write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(hw));
      write_reg(CFG_HALF_HEIGHT, CFG_DATA_W'(hh));
      setting_count++;

      for (int k = 0; k < PHASE_LEN; k++) begin
        if (k % 30 == 0) steady = ($urandom_range(0, 4) == 0);
        // Now and then the sender drains the block before going on.
        if ($urandom_range(0, 59) == 0) wait_idle();
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // Depth between the near plane and one step past the far plane.
          lo = (cur_near < 1) ? 1 : cur_near;
          hi = cur_far + cur_step;
          if (hi > MAX_DEPTH) hi = MAX_DEPTH;
          if (hi < lo) hi = lo;
          d = lo + longint'($urandom_range(0, hi - lo));
        end else if (pick < 9) begin
          // Right at the wrap threshold.
          d = cur_near + cur_step + longint'($urandom_range(0, 2)) - 1;
        end else begin
          d = $urandom_range(1, MAX_DEPTH);
        end
        if (d < 1) d = 1;
        if (d > MAX_DEPTH) d = MAX_DEPTH;
        r.idx   = IDX_W'($urandom_range(0, STAR_COUNT - 1));
        r.x     = $signed($urandom) >>> $urandom_range(0, 31);
        r.y     = $signed($urandom) >>> $urandom_range(0, 31);
        r.z     = d[DEPTH_W-1:0];
        r.typed = 1'b0;
        r.want  = '0;
        send_star(r);
      end
    end

    steady = 1'b0;
    wait_idle();
    $display("Checked %0d projected stars (%0d wrapped) from %0d directed rows", checked_count,
             wrap_seen, plan.size());
    $display("and %0d random plane settings with random sender and receiver stalls.",
             setting_count);
    if (fault_count == 0 && expected_proj.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d faults, %0d results missing", fault_count, expected_proj.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
